[hw/rtl/imubfd_pkg.sv]
// Shared constants and types for the IMU burst frame decoder.
package imubfd_pkg;

    localparam int GAIN_FRAC_BITS = 14;

    localparam int FULL_LEN  = 22;
    localparam int SHORT_LEN = 12;

    localparam int COUNT_W = 5;
    localparam int CFG_W   = 48;
    localparam int IDX_W   = 3;

    localparam logic [7:0] ST2_OVERFLOW_MASK = 8'h08;
    localparam logic [7:0] ST1_READY_MASK    = 8'h01;

    localparam logic [COUNT_W-1:0] FULL_LAST  = COUNT_W'(FULL_LEN - 1);
    localparam logic [COUNT_W-1:0] SHORT_LAST = COUNT_W'(SHORT_LEN - 1);

    localparam logic [IDX_W-1:0] REG_FRAME_MODE = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACC_BIAS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GYRO_BIAS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAG_OFFSET = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAG_GAIN   = 3'd4;

    localparam logic [CFG_W-1:0] MAG_GAIN_RESET = 48'h4000_4000_4000;

    localparam int PROD_W = 34;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (GAIN_FRAC_BITS - 1);

    typedef struct packed {
        logic [2:0][15:0] acc;
        logic [2:0][15:0] gyro;
        logic [2:0][15:0] mag;
        logic             full;
        logic             overflow;
        logic             ready;
        logic [47:0]      time_us;
    } frame_t;

endpackage

[hw/rtl/imu_burst_frame_decoder_core.sv]
// IMU burst frame decoder: byte collection, bias removal and magnetometer correction.
// The frame's last byte loads the capture register; the frame then moves to the result
// register, raising m_valid. Throughput: one byte per cycle; the two registers form a
// two-entry pipeline, and input stalls only while both are full and m_ready is low.
// Reset (aresetn low, synchronous) clears the byte count, held magnetometer value and
// time, pipeline valid flags, and restores register defaults (full frame, unity gains).
module imu_burst_frame_decoder_core (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_frame_start,
    input  logic [47:0]        s_time_us,

    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_acc_x,
    output logic signed [16:0] m_acc_y,
    output logic signed [16:0] m_acc_z,
    output logic signed [16:0] m_gyro_x,
    output logic signed [16:0] m_gyro_y,
    output logic signed [16:0] m_gyro_z,
    output logic signed [17:0] m_mag_x,
    output logic signed [17:0] m_mag_y,
    output logic signed [17:0] m_mag_z,
    output logic               m_mag_fresh,
    output logic               m_status,
    output logic [47:0]        m_mag_time
);

    logic        frame_mode_reg;
    logic [47:0] acc_bias_reg;
    logic [47:0] gyro_bias_reg;
    logic [47:0] mag_offset_reg;
    logic [47:0] mag_gain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg <= 1'b1;
            acc_bias_reg   <= '0;
            gyro_bias_reg  <= '0;
            mag_offset_reg <= '0;
            mag_gain_reg   <= imubfd_pkg::MAG_GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                imubfd_pkg::REG_FRAME_MODE: frame_mode_reg <= cfg_wdata[0];
                imubfd_pkg::REG_ACC_BIAS:   acc_bias_reg   <= cfg_wdata;
                imubfd_pkg::REG_GYRO_BIAS:  gyro_bias_reg  <= cfg_wdata;
                imubfd_pkg::REG_MAG_OFFSET: mag_offset_reg <= cfg_wdata;
                imubfd_pkg::REG_MAG_GAIN:   mag_gain_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Byte collection.
    logic [imubfd_pkg::COUNT_W-1:0] byte_count_reg;
    logic [7:0]                     frame_reg [imubfd_pkg::FULL_LEN];
    logic [7:0]                     cur_byte  [imubfd_pkg::FULL_LEN];
    logic [imubfd_pkg::COUNT_W-1:0] idx;
    logic [imubfd_pkg::COUNT_W-1:0] last_idx;
    logic                           in_range;
    logic                           is_last;
    logic                           s_fire;
    logic                           advance;

    imubfd_pkg::frame_t frame_next;
    imubfd_pkg::frame_t cap_reg;
    logic               cap_valid_reg;

    assign idx      = s_frame_start ? '0 : byte_count_reg;
    assign last_idx = frame_mode_reg ? imubfd_pkg::FULL_LAST : imubfd_pkg::SHORT_LAST;
    assign in_range = idx <= last_idx;
    assign is_last  = idx == last_idx;
    assign s_fire   = s_valid && s_ready;
    assign advance  = cap_valid_reg && (!m_valid || m_ready);
    assign s_ready  = !cap_valid_reg || advance;

    always_comb begin
        for (int k = 0; k < imubfd_pkg::FULL_LEN; k++) begin
            cur_byte[k] = (idx == imubfd_pkg::COUNT_W'(k)) ? s_data_byte : frame_reg[k];
        end
        for (int k = 0; k < 3; k++) begin
            frame_next.acc[k]  = {cur_byte[2*k], cur_byte[2*k+1]};
            frame_next.gyro[k] = {cur_byte[6+2*k], cur_byte[7+2*k]};
            frame_next.mag[k]  = {cur_byte[16+2*k], cur_byte[15+2*k]};
        end
        frame_next.full     = frame_mode_reg;
        frame_next.overflow = frame_mode_reg && |(cur_byte[21] & imubfd_pkg::ST2_OVERFLOW_MASK);
        frame_next.ready    = |(cur_byte[14] & imubfd_pkg::ST1_READY_MASK);
        frame_next.time_us  = s_time_us;
    end

    always_ff @(posedge aclk) begin
        if (s_fire && in_range) begin
            for (int k = 0; k < imubfd_pkg::FULL_LEN; k++) begin
                if (idx == imubfd_pkg::COUNT_W'(k)) begin
                    frame_reg[k] <= s_data_byte;
                end
            end
        end
        if (s_fire && in_range && is_last) begin
            cap_reg <= frame_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            cap_valid_reg  <= 1'b0;
        end else begin
            if (s_fire && in_range) begin
                byte_count_reg <= idx + 1'b1;
            end
            if (s_fire && in_range && is_last) begin
                cap_valid_reg <= 1'b1;
            end else if (advance) begin
                cap_valid_reg <= 1'b0;
            end
        end
    end

    // Result computation.
    logic [2:0][15:0] held_mag_reg;
    logic [47:0]      held_time_reg;
    logic             take_new;
    logic [2:0][15:0] mag_src;
    logic [47:0]      time_src;

    logic signed [16:0] acc_res  [3];
    logic signed [16:0] gyro_res [3];
    logic signed [16:0] mag_diff [3];
    logic signed [16:0] gain_s   [3];
    logic signed [imubfd_pkg::PROD_W-1:0] mag_prod [3];
    logic signed [imubfd_pkg::PROD_W-1:0] mag_shr  [3];
    logic signed [17:0] mag_sat  [3];

    assign take_new = cap_reg.full && !cap_reg.overflow && cap_reg.ready;
    assign mag_src  = take_new ? cap_reg.mag : held_mag_reg;
    assign time_src = take_new ? cap_reg.time_us : held_time_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            acc_res[k]  = $signed({cap_reg.acc[k][15], cap_reg.acc[k]})
                        - $signed({acc_bias_reg[16*k+15], acc_bias_reg[16*k +: 16]});
            gyro_res[k] = $signed({cap_reg.gyro[k][15], cap_reg.gyro[k]})
                        - $signed({gyro_bias_reg[16*k+15], gyro_bias_reg[16*k +: 16]});
            mag_diff[k] = $signed({mag_src[k][15], mag_src[k]})
                        - $signed({mag_offset_reg[16*k+15], mag_offset_reg[16*k +: 16]});
            gain_s[k]   = $signed({1'b0, mag_gain_reg[16*k +: 16]});
            mag_prod[k] = mag_diff[k] * gain_s[k];
            mag_shr[k]  = (mag_prod[k] + imubfd_pkg::ROUND_HALF) >>> imubfd_pkg::GAIN_FRAC_BITS;
            if (mag_shr[k][imubfd_pkg::PROD_W-1:17] == '0
                    || mag_shr[k][imubfd_pkg::PROD_W-1:17] == '1) begin
                mag_sat[k] = mag_shr[k][17:0];
            end else if (mag_shr[k][imubfd_pkg::PROD_W-1]) begin
                mag_sat[k] = 18'sh20000;
            end else begin
                mag_sat[k] = 18'sh1FFFF;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_mag_reg  <= '0;
            held_time_reg <= '0;
            m_valid       <= 1'b0;
        end else begin
            if (advance) begin
                m_valid <= 1'b1;
                if (take_new) begin
                    held_mag_reg  <= cap_reg.mag;
                    held_time_reg <= cap_reg.time_us;
                end
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (cap_reg.overflow) begin
                m_acc_x     <= '0;
                m_acc_y     <= '0;
                m_acc_z     <= '0;
                m_gyro_x    <= '0;
                m_gyro_y    <= '0;
                m_gyro_z    <= '0;
                m_mag_x     <= '0;
                m_mag_y     <= '0;
                m_mag_z     <= '0;
                m_mag_fresh <= 1'b0;
                m_status    <= 1'b1;
                m_mag_time  <= '0;
            end else begin
                m_acc_x     <= acc_res[0];
                m_acc_y     <= acc_res[1];
                m_acc_z     <= acc_res[2];
                m_gyro_x    <= gyro_res[0];
                m_gyro_y    <= gyro_res[1];
                m_gyro_z    <= gyro_res[2];
                m_status    <= 1'b0;
                m_mag_fresh <= take_new;
                if (cap_reg.full) begin
                    m_mag_x    <= mag_sat[0];
                    m_mag_y    <= mag_sat[1];
                    m_mag_z    <= mag_sat[2];
                    m_mag_time <= time_src;
                end else begin
                    m_mag_x    <= '0;
                    m_mag_y    <= '0;
                    m_mag_z    <= '0;
                    m_mag_time <= '0;
                end
            end
        end
    end

endmodule
